// ===== hw/rtl/gwm_pkg.sv =====
// Shared types and constants for the glob wildcard matcher.
// Used by every module of the block; no dependencies.

package gwm_pkg;

	// Pattern capacity and derived widths
	localparam int PATTERN_MAX = 32;
	localparam int POS_W       = PATTERN_MAX + 1;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int SCAN_LVLS   = $clog2(POS_W);

	// Special pattern bytes
	localparam logic [7:0] STAR_BYTE  = 8'h2A;
	localparam logic [7:0] QMARK_BYTE = 8'h3F;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// Item kinds
	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_NAME   = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	// Classified command handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] sym;
		logic       is_star;
		logic       is_qmark;
	} cmd_t;

	// One result beat
	typedef struct packed {
		logic matched;
		logic overflow;
	} res_t;

endpackage

// ===== hw/rtl/gwm_front.sv =====
// Front end: takes input beats and classifies the symbol.
// Depends on gwm_pkg.

module gwm_front (
	input  logic          push,
	output logic          full,
	input  logic [1:0]    kind,
	input  logic [7:0]    symbol,
	output logic          q_push,
	output gwm_pkg::cmd_t q_data,
	input  logic          q_full
);
	import gwm_pkg::*;

	// Flow control follows the command queue
	assign full   = q_full;
	assign q_push = push & ~q_full;

	// Decode kind and tag the special pattern bytes
	always_comb begin
		q_data.kind     = kind_t'(kind);
		q_data.sym      = symbol;
		q_data.is_star  = (symbol == STAR_BYTE);
		q_data.is_qmark = (symbol == QMARK_BYTE);
	end

endmodule

// ===== hw/rtl/gwm_cmdq.sv =====
// Short command queue between front and back.
// Depends on gwm_pkg.

module gwm_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gwm_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output gwm_pkg::cmd_t rdata,
	output logic          valid
);
	import gwm_pkg::*;

	cmd_t                  ent_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign rdata   = ent_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/gwm_back.sv =====
// Back end: pattern store, active-position vector and result buffer.
// Depends on gwm_pkg.

module gwm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  gwm_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output logic          matched,
	output logic          pattern_overflow
);
	import gwm_pkg::*;

	// Pattern store (no reset; only entries below the length are used)
	logic [7:0]       pat_q   [PATTERN_MAX];
	logic             star_q  [PATTERN_MAX];
	logic             qmark_q [PATTERN_MAX];

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [POS_W-1:0] act_q;   // active positions
	logic [POS_W-1:0] arm_q;   // closure of position zero for the current pattern

	// Result buffer, two entries
	res_t             res_q [2];
	logic             res_wptr_q;
	logic             res_rptr_q;
	logic [1:0]       res_cnt_q;
	logic             res_full;
	logic             res_push;
	logic             res_pop;

	logic             exec;
	logic             room;
	logic [PATTERN_MAX-1:0] len_mask;
	logic [POS_W-1:0] step_vec;
	logic [POS_W-1:0] closed_vec;
	logic [POS_W-1:0] arm_next;

	// Issue: an end beat needs room in the result buffer
	assign res_full = (res_cnt_q == 2'd2);
	assign exec     = cmd_valid & ((cmd.kind != KIND_END) | ~res_full);
	assign cmd_pop  = exec;
	assign room     = (len_q < LEN_W'(PATTERN_MAX));

	// Positions that hold a pattern byte
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			len_mask[i] = (LEN_W'(i) < len_q);
		end
	end

	// One name byte: advance every live position in parallel
	always_comb begin
		step_vec = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (act_q[i] && len_mask[i]) begin
				if (star_q[i]) begin
					step_vec[i] = 1'b1;
				end else if (qmark_q[i] || (pat_q[i] == cmd.sym)) begin
					step_vec[i+1] = 1'b1;
				end
			end
		end
	end

	// Star closure as a parallel prefix: position i+1 inherits i over a star
	always_comb begin
		logic [POS_W-1:0] g;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] gn;
		logic [POS_W-1:0] pn;
		g    = step_vec;
		p    = '0;
		for (int i = 1; i < POS_W; i++) begin
			p[i] = star_q[i-1] & len_mask[i-1];
		end
		for (int l = 0; l < SCAN_LVLS; l++) begin
			gn = g;
			pn = p;
			for (int i = 0; i < POS_W; i++) begin
				if (i >= (1 << l)) begin
					gn[i] = g[i] | (p[i] & g[i - (1 << l)]);
					pn[i] = p[i] & p[i - (1 << l)];
				end
			end
			g = gn;
			p = pn;
		end
		closed_vec = g;
	end

	// Appending a star extends the re-arm vector by one position
	always_comb begin
		arm_next = arm_q;
		for (int i = 1; i < POS_W; i++) begin
			if (LEN_W'(i - 1) == len_q) begin
				arm_next[i] = arm_q[i] | (arm_q[i-1] & cmd.is_star);
			end
		end
	end

	// Pattern byte write
	always_ff @(posedge clk) begin
		if (exec && (cmd.kind == KIND_APPEND) && room) begin
			pat_q[len_q[IDX_W-1:0]]   <= cmd.sym;
			star_q[len_q[IDX_W-1:0]]  <= cmd.is_star;
			qmark_q[len_q[IDX_W-1:0]] <= cmd.is_qmark;
		end
	end

	// Matcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			act_q <= POS_W'(1);
			arm_q <= POS_W'(1);
		end else if (exec) begin
			case (cmd.kind)
				KIND_CLEAR: begin
					len_q <= '0;
					ovf_q <= 1'b0;
					act_q <= POS_W'(1);
					arm_q <= POS_W'(1);
				end
				KIND_APPEND: begin
					if (room) begin
						len_q <= len_q + 1'b1;
						arm_q <= arm_next;
						act_q <= arm_next;
					end else begin
						ovf_q <= 1'b1;
						act_q <= arm_q;
					end
				end
				KIND_NAME: begin
					act_q <= closed_vec;
				end
				KIND_END: begin
					act_q <= arm_q;
				end
				default: begin
					act_q <= act_q;
				end
			endcase
		end
	end

	// Result buffer
	assign res_push = exec & (cmd.kind == KIND_END);
	assign res_pop  = pop & ~empty;
	assign empty    = (res_cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wptr_q].matched  <= act_q[len_q];
			res_q[res_wptr_q].overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q <= 1'b0;
			res_rptr_q <= 1'b0;
			res_cnt_q  <= '0;
		end else begin
			if (res_push) begin
				res_wptr_q <= ~res_wptr_q;
			end
			if (res_pop) begin
				res_rptr_q <= ~res_rptr_q;
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	assign matched          = res_q[res_rptr_q].matched;
	assign pattern_overflow = res_q[res_rptr_q].overflow;

`ifndef SYNTH
	logic [POS_W-1:0] upto_len;
	always_comb begin
		for (int i = 0; i < POS_W; i++) begin
			upto_len[i] = (LEN_W'(i) <= len_q);
		end
	end

	// No position beyond the pattern end is ever live
	a_act_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q & ~upto_len) == '0)
		else $error("active position beyond pattern length");

	// Position zero is always part of the re-arm vector
	a_arm_base: assert property (@(posedge clk) disable iff (!arst_n)
		arm_q[0])
		else $error("re-arm vector lost position zero");

	// Clear leaves an empty pattern armed at position zero
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (cmd.kind == KIND_CLEAR) |=> (act_q == POS_W'(1)) && !ovf_q && (len_q == '0))
		else $error("clear did not reset matcher state");

	// Length stays within capacity and never grows on a full pattern
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (cmd.kind == KIND_APPEND) && !room |=> ovf_q && $stable(len_q))
		else $error("append past capacity not flagged");
`endif

endmodule

// ===== hw/rtl/glob_wildcard_matcher_core.sv =====
// Anchored glob matcher ('*' and '?'), top level.
// Beats are executed from the command queue; an end-of-name result is registered
// in the result buffer that drives the result ports. Throughput: one beat per cycle
// while the command queue has room; the star closure is a parallel prefix over the
// active-position vector. End beats wait only while two results are unpopped.
// Reset clears length, overflow flag and queues, and arms position zero only.
// Depends on gwm_pkg, gwm_front, gwm_cmdq, gwm_back.

module glob_wildcard_matcher_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] kind,
	input  logic [7:0] symbol,
	output logic       empty,
	input  logic       pop,
	output logic       matched,
	output logic       pattern_overflow
);
	import gwm_pkg::*;

	logic q_push;
	logic q_full;
	cmd_t q_wdata;
	cmd_t q_rdata;
	logic q_valid;
	logic q_pop;

	gwm_front u_front (
		.push   (push),
		.full   (full),
		.kind   (kind),
		.symbol (symbol),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	gwm_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	gwm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (q_valid),
		.cmd              (q_rdata),
		.cmd_pop          (q_pop),
		.empty            (empty),
		.pop              (pop),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

endmodule
